FILE: rtl/core/multitouch_slot_frame_queue_defines.svh
// Assertion macros for the multitouch slot frame queue
`ifndef MULTITOUCH_SLOT_FRAME_QUEUE_DEFINES_SVH
`define MULTITOUCH_SLOT_FRAME_QUEUE_DEFINES_SVH
// same-cycle implication
`define MSFQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msfq assertion failed");
// next-cycle implication
`define MSFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msfq assertion failed");
`endif

FILE: rtl/core/msfq_pkg.sv
// Package: constants, payload and control types of the slot frame queue
`default_nettype none
package msfq_pkg;
   localparam int MAX_SLOTS    = 8;
   localparam int SLOT_W       = 3;
   localparam int FRAME_DEPTH  = 16;
   localparam int FRAME_W      = 4;
   localparam int CNT_W        = 5;
   localparam int READERS      = 2;
   localparam int READER_W     = 1;
   localparam int MAX_REPORTED = 8;
   localparam int REP_W        = 4;
   localparam int BUF_W        = 3;

   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [2:0] EVC_SLOT  = 3'd0;
   localparam logic [2:0] EVC_TRACK = 3'd1;
   localparam logic [2:0] EVC_X     = 3'd2;
   localparam logic [2:0] EVC_Y     = 3'd3;

   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_DOWN = 2'd1;
   localparam logic [1:0] EV_HOLD = 2'd2;
   localparam logic [1:0] EV_UP   = 2'd3;

   localparam logic [1:0] CSR_SLOTS   = 2'd0;
   localparam logic [1:0] CSR_READERS = 2'd1;
   localparam logic [1:0] CSR_NOTIFY  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         event_code;
      logic signed [31:0] event_value;
      logic [31:0]        frame_time;
      logic               reader;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic               pressed;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               was_cancelled;
      logic               more_pending;
      logic [1:0]         point_event;
      logic [2:0]         point_slot;
      logic [31:0]        point_stamp;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic [15:0] x;
      logic [15:0] y;
      logic [1:0]  ev;
   } point_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [1:0]        ev;
      logic [15:0]       x;
      logic [15:0]       y;
   } change_type;

   typedef struct packed {
      logic              accept;
      logic              fe_write;
      logic              rd_issue;
      logic              emit;
      logic [SLOT_W-1:0] slot;
      logic [REP_W-1:0]  emit_idx;
   } cmd_type;

   typedef struct packed {
      logic             read_have;
      logic [REP_W-1:0] buf_count;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/core/msfq_ctrl.sv
// Controller: sequences frame writes, ring walks and result emission
`default_nettype none
module msfq_ctrl import msfq_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [1:0]  req_mode,
   input  status_type  status,
   output logic        busy,
   output cmd_type     cmd
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FRAME = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [REP_W-1:0]  eidx_ff, eidx_in;
   logic              accept;
   logic              slot_end;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign slot_end = (slot_ff == SLOT_W'(MAX_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      eidx_in  = eidx_ff;
      case (state_ff)
         ST_IDLE: begin
            slot_in = '0;
            eidx_in = '0;
            if (accept) begin
               if (req_mode == MODE_FRAME) begin
                  state_in = ST_FRAME;
               end else if (req_mode == MODE_READ) begin
                  state_in = status.read_have ? ST_ISSUE : ST_EMIT;
               end
            end
         end
         ST_FRAME: begin
            slot_in = slot_ff + 1'b1;
            if (slot_end) state_in = ST_IDLE;
         end
         ST_ISSUE: begin
            slot_in = slot_ff + 1'b1;
            if (slot_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            eidx_in = eidx_ff + 1'b1;
            if (eidx_ff == status.buf_count) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         eidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         eidx_ff  <= eidx_in;
      end
   end

   always_comb begin
      cmd.accept   = accept;
      cmd.fe_write = (state_ff == ST_FRAME);
      cmd.rd_issue = (state_ff == ST_ISSUE);
      cmd.emit     = (state_ff == ST_EMIT);
      cmd.slot     = slot_ff;
      cmd.emit_idx = eidx_ff;
   end
endmodule
`default_nettype wire

FILE: rtl/core/msfq_datapath.sv
// Datapath: contact registers, frame ring, reader cursors and result formatting
`default_nettype none
module msfq_datapath import msfq_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  cmd_type     cmd,
   input  req_type     req_data,
   input  wire         csr_write,
   input  wire  [1:0]  csr_index,
   input  wire  [3:0]  csr_data,
   output status_type  status,
   output rsp_type     rsp_data
);
   logic [3:0]          slots_ff;
   logic [1:0]          readers_ff;
   logic                notify_en_ff;
   logic [31:0]         cur_tr_ff [MAX_SLOTS];
   logic [15:0]         cur_x_ff [MAX_SLOTS];
   logic [15:0]         cur_y_ff [MAX_SLOTS];
   logic [31:0]         prev_tr_ff [MAX_SLOTS];
   logic [SLOT_W-1:0]   chosen_low_ff;
   logic                chosen_big_ff;
   logic [CNT_W-1:0]    wc_ff;
   logic [CNT_W-1:0]    rc_ff [READERS];
   logic [READERS-1:0]  cancel_ff;
   logic [READERS-1:0]  block_ff;
   logic                nb_ff;
   logic                shown_act_ff [READERS];
   logic [15:0]         shown_x_ff [READERS];
   logic [15:0]         shown_y_ff [READERS];
   logic [READER_W-1:0] r_ff;
   logic                have_ff;
   logic                cancelled_ff;
   logic                notify_ff;
   logic                nb_orig_ff;
   logic                any_ff;
   logic [FRAME_W-1:0]  fe_idx_ff;
   logic [FRAME_W-1:0]  rd_idx_ff;
   logic                proc_valid_ff;
   logic [SLOT_W-1:0]   proc_slot_ff;
   logic [REP_W-1:0]    buf_count_ff;
   change_type          buf_ff [MAX_REPORTED];
   point_type           ring_mem [MAX_SLOTS*FRAME_DEPTH];
   point_type           ring_q_ff;
   logic [31:0]         stamp_mem [FRAME_DEPTH];
   logic [31:0]         stamp_q_ff;

   logic [3:0]          slot_lim;
   logic [1:0]          reader_lim;
   logic                slot_ok;
   logic                overflow;
   logic                is_event, is_frame, is_reset, is_read;
   logic                read_have;
   point_type           fe_point;
   logic                fe_act, fe_was;
   logic                proc_in_range;
   logic [REP_W-1:0]    emit_m1;
   change_type          buf_sel;
   logic [CNT_W-1:0]    lag;
   logic [CNT_W-1:0]    rr_count;

   assign slot_lim   = (slots_ff > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : slots_ff;
   assign reader_lim = (readers_ff > 2'(READERS)) ? 2'(READERS) : readers_ff;
   assign slot_ok    = !chosen_big_ff && ({1'b0, chosen_low_ff} < slot_lim);
   assign is_event   = cmd.accept && (req_data.mode == MODE_EVENT);
   assign is_frame   = cmd.accept && (req_data.mode == MODE_FRAME);
   assign is_reset   = cmd.accept && (req_data.mode == MODE_RESET);
   assign is_read    = cmd.accept && (req_data.mode == MODE_READ);
   assign rr_count   = rc_ff[req_data.reader];
   assign read_have  = !cancel_ff[req_data.reader] && (rr_count != wc_ff);

   always_comb begin
      overflow = 1'b0;
      lag      = '0;
      for (int i = 0; i < READERS; i++) begin
         lag = wc_ff - rc_ff[i];
         if ((2'(i) < reader_lim) && lag[CNT_W-1]) overflow = 1'b1;
      end
   end

   always_comb begin
      fe_act = !cur_tr_ff[cmd.slot][31];
      fe_was = !prev_tr_ff[cmd.slot][31];
      fe_point.active = fe_act;
      fe_point.x      = cur_x_ff[cmd.slot];
      fe_point.y      = cur_y_ff[cmd.slot];
      if ({1'b0, cmd.slot} >= slot_lim) begin
         fe_point.ev = EV_NONE;
      end else if (fe_act) begin
         fe_point.ev = (prev_tr_ff[cmd.slot] == cur_tr_ff[cmd.slot]) ? EV_HOLD : EV_DOWN;
      end else begin
         fe_point.ev = fe_was ? EV_UP : EV_NONE;
      end
   end

   assign proc_in_range = ({1'b0, proc_slot_ff} < slot_lim);

   always_ff @(posedge clock) begin
      if (cmd.fe_write) ring_mem[{fe_idx_ff, cmd.slot}] <= fe_point;
      if (cmd.rd_issue) ring_q_ff <= ring_mem[{rd_idx_ff, cmd.slot}];
      if (is_frame) stamp_mem[wc_ff[FRAME_W-1:0]] <= req_data.frame_time;
      if (is_read && read_have) stamp_q_ff <= stamp_mem[rr_count[FRAME_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (is_event && (req_data.event_code == EVC_X) && slot_ok) begin
         cur_x_ff[chosen_low_ff] <= req_data.event_value[15:0];
      end
      if (is_event && (req_data.event_code == EVC_Y) && slot_ok) begin
         cur_y_ff[chosen_low_ff] <= req_data.event_value[15:0];
      end
      if (reset || is_reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            cur_x_ff[i] <= '0;
            cur_y_ff[i] <= '0;
         end
      end
      if (proc_valid_ff && have_ff && notify_ff && notify_en_ff && proc_in_range
            && (ring_q_ff.ev != EV_NONE) && (buf_count_ff < REP_W'(MAX_REPORTED))) begin
         buf_ff[buf_count_ff[BUF_W-1:0]] <= '{slot: proc_slot_ff, ev: ring_q_ff.ev,
                                             x: ring_q_ff.x, y: ring_q_ff.y};
      end
      if (is_read) begin
         r_ff         <= req_data.reader;
         rd_idx_ff    <= rr_count[FRAME_W-1:0];
         cancelled_ff <= cancel_ff[req_data.reader];
         have_ff      <= read_have;
         notify_ff    <= (req_data.reader == '0) && !nb_ff;
         nb_orig_ff   <= (req_data.reader == '0) && nb_ff;
      end
      if (is_frame) fe_idx_ff <= wc_ff[FRAME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= '0;
         readers_ff    <= '0;
         notify_en_ff  <= 1'b0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            cur_tr_ff[i]  <= '1;
            prev_tr_ff[i] <= '1;
         end
         chosen_low_ff <= '0;
         chosen_big_ff <= 1'b0;
         wc_ff         <= '0;
         for (int i = 0; i < READERS; i++) begin
            rc_ff[i]        <= '0;
            shown_act_ff[i] <= 1'b0;
            shown_x_ff[i]   <= '0;
            shown_y_ff[i]   <= '0;
         end
         cancel_ff     <= '0;
         block_ff      <= '0;
         nb_ff         <= 1'b0;
         any_ff        <= 1'b0;
         proc_valid_ff <= 1'b0;
         proc_slot_ff  <= '0;
         buf_count_ff  <= '0;
      end else begin
         proc_valid_ff <= cmd.rd_issue;
         proc_slot_ff  <= cmd.slot;
         if (csr_write) begin
            case (csr_index)
               CSR_SLOTS:   slots_ff     <= csr_data;
               CSR_READERS: readers_ff   <= csr_data[1:0];
               CSR_NOTIFY:  notify_en_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (is_event) begin
            if (req_data.event_code == EVC_SLOT) begin
               chosen_low_ff <= req_data.event_value[SLOT_W-1:0];
               chosen_big_ff <= |req_data.event_value[31:SLOT_W];
            end else if ((req_data.event_code == EVC_TRACK) && slot_ok) begin
               cur_tr_ff[chosen_low_ff] <= req_data.event_value;
            end
         end
         if (is_reset) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
               cur_tr_ff[i]  <= '1;
               prev_tr_ff[i] <= '1;
            end
            chosen_low_ff <= '0;
            chosen_big_ff <= 1'b0;
            nb_ff         <= 1'b0;
            for (int i = 0; i < READERS; i++) rc_ff[i] <= wc_ff;
            cancel_ff     <= '1;
            block_ff      <= '0;
         end
         if (is_frame && overflow) begin
            nb_ff     <= 1'b1;
            for (int i = 0; i < READERS; i++) rc_ff[i] <= wc_ff;
            cancel_ff <= '1;
            block_ff  <= '1;
         end
         if (cmd.fe_write) begin
            prev_tr_ff[cmd.slot] <= cur_tr_ff[cmd.slot];
            if (cmd.slot == SLOT_W'(MAX_SLOTS - 1)) wc_ff <= wc_ff + 1'b1;
         end
         if (is_read) begin
            cancel_ff[req_data.reader] <= 1'b0;
            buf_count_ff               <= '0;
            any_ff                     <= 1'b0;
            if (read_have) begin
               rc_ff[req_data.reader] <= rr_count + 1'b1;
            end else if (cancel_ff[req_data.reader]) begin
               shown_act_ff[req_data.reader] <= 1'b0;
            end
         end
         if (proc_valid_ff) begin
            if (proc_slot_ff == SLOT_W'(r_ff)) begin
               shown_x_ff[r_ff] <= ring_q_ff.x;
               shown_y_ff[r_ff] <= ring_q_ff.y;
               if (block_ff[r_ff]) begin
                  shown_act_ff[r_ff] <= 1'b0;
                  if (!ring_q_ff.active) block_ff[r_ff] <= 1'b0;
               end else begin
                  shown_act_ff[r_ff] <= ring_q_ff.active;
               end
            end
            if (proc_in_range && ring_q_ff.active) any_ff <= 1'b1;
            if (notify_ff && notify_en_ff && proc_in_range && (ring_q_ff.ev != EV_NONE)
                  && (buf_count_ff < REP_W'(MAX_REPORTED))) begin
               buf_count_ff <= buf_count_ff + 1'b1;
            end
         end
         if (cmd.emit && (cmd.emit_idx == '0) && have_ff && nb_orig_ff && !any_ff) begin
            nb_ff <= 1'b0;
         end
      end
   end

   assign emit_m1 = cmd.emit_idx - 1'b1;
   assign buf_sel = buf_ff[emit_m1[BUF_W-1:0]];

   always_comb begin
      rsp_data = '0;
      rsp_data.last = (cmd.emit_idx == buf_count_ff);
      if (cmd.emit_idx == '0) begin
         rsp_data.kind          = 1'b0;
         rsp_data.pressed       = shown_act_ff[r_ff];
         rsp_data.pos_x         = shown_x_ff[r_ff];
         rsp_data.pos_y         = shown_y_ff[r_ff];
         rsp_data.was_cancelled = cancelled_ff;
         rsp_data.more_pending  = (rc_ff[r_ff] != wc_ff);
      end else begin
         rsp_data.kind        = 1'b1;
         rsp_data.pos_x       = buf_sel.x;
         rsp_data.pos_y       = buf_sel.y;
         rsp_data.point_event = buf_sel.ev;
         rsp_data.point_slot  = buf_sel.slot;
         rsp_data.point_stamp = stamp_q_ff;
      end
   end

   assign status.read_have = read_have;
   assign status.buf_count = buf_count_ff;
endmodule
`default_nettype wire

FILE: rtl/core/multitouch_slot_frame_queue.sv
// Top level: multitouch slot frame queue, controller plus datapath
// Events and resets are taken in idle without leaving it; busy stays low.
// A frame end is accepted, then makes one ring write per slot (8 slots).
// A read walks the ring slot by slot and then drains, when a frame is consumed,
// then gives one result per cycle: the pointer item and up to 8 change items.
// The walk is set by the single ring memory read port, one slot a cycle.
// Synchronous reset clears contacts, cursors, flags and the CSRs at once.
`default_nettype none
`include "multitouch_slot_frame_queue_defines.svh"
module multitouch_slot_frame_queue import msfq_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [3:0]  csr_data
);
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;
   assign rsp_valid = cmd.emit;

   msfq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   msfq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   `MSFQ_ASSERT_NOW(a_rsp_busy, clock, reset, rsp_valid, busy)
   `MSFQ_ASSERT_NEXT(a_read_busy, clock, reset, start && !busy && (req_data.mode == MODE_READ), busy)
   `MSFQ_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_data.last, !rsp_valid && !busy)
endmodule
`default_nettype wire
